// ===== rtl/core/hvtq_pkg.sv =====
// Package for the highest-value task queue: item types, codes and defaults.
// Used by the modules of the block except hvtq_fifo; depends on nothing.
`default_nettype none

package hvtq_pkg;

	localparam int MAX_TASKS_DEF = 32;
	localparam int CMDQ_DEPTH    = 2;
	localparam int RESQ_DEPTH    = 2;

	localparam logic [6:0] PCT_BASE   = 7'd100;
	localparam logic [6:0] ZERO_FLOOR = 7'd10;

	typedef enum logic [1:0] {
		OP_ENQ  = 2'd0,
		OP_REM  = 2'd1,
		OP_PEEK = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FULL     = 3'd3,
		ST_DUP      = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  task_id;
		logic [6:0]  task_value;
		logic [31:0] cpu_ms;
		logic [31:0] budget_ms;
		logic        slice_over;
	} in_item_t;

	typedef struct packed {
		logic [7:0] best_task;
		logic [6:0] result_value;
		logic [2:0] status;
		logic [5:0] queued_count;
	} out_item_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  task_id;
		logic [6:0]  task_value;
		logic [31:0] cpu_ms;
		logic [31:0] diff;
		logic        overrun;
		logic        slice_over;
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/hvtq_fifo.sv =====
// Small register queue used between the parts of the task queue.
// Standalone; no package dependency.
`default_nettype none

module hvtq_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/hvtq_front.sv =====
// Front part: accepts input transactions, classifies them and queues commands.
// Depends on hvtq_pkg and hvtq_fifo.
`default_nettype none

module hvtq_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hvtq_pkg::in_item_t item,
	output logic              full,
	input  logic              pop,
	output hvtq_pkg::cmd_t    cmd,
	output logic              empty
);

	hvtq_pkg::cmd_t                  cls;
	logic [$bits(hvtq_pkg::cmd_t)-1:0] rd_raw;

	always_comb begin
		cls.op         = hvtq_pkg::op_t'(item.action);
		cls.task_id    = item.task_id;
		cls.task_value = item.task_value;
		cls.cpu_ms     = item.cpu_ms;
		cls.diff       = item.cpu_ms - item.budget_ms;
		cls.overrun    = item.cpu_ms > item.budget_ms;
		cls.slice_over = item.slice_over;
	end

	hvtq_fifo #(
		.WIDTH($bits(hvtq_pkg::cmd_t)),
		.DEPTH(hvtq_pkg::CMDQ_DEPTH)
	) u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cls),
		.full  (full),
		.pop   (pop),
		.rdata (rd_raw),
		.empty (empty)
	);

	assign cmd = hvtq_pkg::cmd_t'(rd_raw);

endmodule

`default_nettype wire

// ===== rtl/core/hvtq_back.sv =====
// Back part: value cut, slot scan and slot store of the task queue.
// Depends on hvtq_pkg.
`default_nettype none

module hvtq_back #(
	parameter int MAX_TASKS = hvtq_pkg::MAX_TASKS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_empty,
	input  hvtq_pkg::cmd_t     cmd,
	output logic               cmd_pop,
	input  logic               res_full,
	output logic               res_push,
	output hvtq_pkg::out_item_t res
);

	localparam int IW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam logic [12:0] RECIP = 13'd5243;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_DSQ  = 9'b000000010,
		S_M1   = 9'b000000100,
		S_R1   = 9'b000001000,
		S_M2   = 9'b000010000,
		S_R2   = 9'b000100000,
		S_SCAN = 9'b001000000,
		S_FIN  = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;

	function automatic logic [6:0] cut_value(input logic [6:0] old, input logic [70:0] prod);
		logic [13:0] lim;
		logic [26:0] quo;
		logic [6:0]  res_v;
		lim = 14'(old) * 14'(hvtq_pkg::PCT_BASE);
		quo = 27'(prod[13:0]) * 27'(RECIP);
		if (old == '0) begin
			res_v = hvtq_pkg::ZERO_FLOOR;
		end else if ((|prod[70:64]) || (prod[63:0] >= 64'(lim))) begin
			res_v = '0;
		end else begin
			res_v = old - 7'(quo[26:19]);
		end
		return res_v;
	endfunction

	state_t         state_q;
	hvtq_pkg::cmd_t cmd_q;
	logic [6:0]     cur_q;
	logic [63:0]    dsq_q;
	logic [70:0]    prod_q;
	logic [IW:0]    cnt_q;

	logic [MAX_TASKS-1:0] valid_q;
	logic [7:0]  task_mem [MAX_TASKS];
	logic [6:0]  val_mem  [MAX_TASKS];
	logic [15:0] age_mem  [MAX_TASKS];

	logic          rd_vld_s1;
	logic          rd_valid_s1;
	logic [IW-1:0] rd_idx_s1;
	logic [7:0]    rd_task_s1;
	logic [6:0]    rd_val_s1;
	logic [15:0]   rd_age_s1;

	logic          found_q;
	logic [IW-1:0] found_idx_q;
	logic          free_seen_q;
	logic [IW-1:0] free_idx_q;
	logic          bfound_q;
	logic [IW-1:0] bidx_q;
	logic [6:0]    bval_q;
	logic [7:0]    btask_q;
	logic [15:0]   bdist_q;

	logic [15:0]   arrival_q;
	logic [IW-1:0] best_idx_q;
	logic [6:0]    best_val_q;
	logic [7:0]    best_task_q;
	logic [CW-1:0] count_q;
	hvtq_pkg::out_item_t res_q;

	logic [IW-1:0] rd_addr;
	logic [15:0]   age_dist;
	logic          enq_ok;
	logic          mem_we;
	logic          peek_hit;

	assign rd_addr  = cnt_q[IW-1:0];
	assign age_dist = arrival_q - rd_age_s1;
	assign enq_ok   = !found_q && (count_q < CW'(MAX_TASKS)) && free_seen_q;
	assign mem_we   = (state_q == S_FIN) && (cmd_q.op == hvtq_pkg::OP_ENQ) && enq_ok;
	assign peek_hit = (cmd.op == hvtq_pkg::OP_PEEK) && (count_q != '0);
	assign cmd_pop  = (state_q == S_IDLE) && !cmd_empty;
	assign res_push = (state_q == S_OUT) && !res_full;
	assign res      = res_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			task_mem[free_idx_q] <= cmd_q.task_id;
			val_mem[free_idx_q]  <= cur_q;
			age_mem[free_idx_q]  <= arrival_q;
		end
		rd_task_s1  <= task_mem[rd_addr];
		rd_val_s1   <= val_mem[rd_addr];
		rd_age_s1   <= age_mem[rd_addr];
		rd_valid_s1 <= valid_q[rd_addr];
		rd_idx_s1   <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			cur_q       <= '0;
			dsq_q       <= '0;
			prod_q      <= '0;
			cnt_q       <= '0;
			valid_q     <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			found_idx_q <= '0;
			free_seen_q <= 1'b0;
			free_idx_q  <= '0;
			bfound_q    <= 1'b0;
			bidx_q      <= '0;
			bval_q      <= '0;
			btask_q     <= '0;
			bdist_q     <= '0;
			arrival_q   <= '0;
			best_idx_q  <= '0;
			best_val_q  <= '0;
			best_task_q <= '0;
			count_q     <= '0;
			res_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					cnt_q       <= '0;
					rd_vld_s1   <= 1'b0;
					found_q     <= 1'b0;
					free_seen_q <= 1'b0;
					bfound_q    <= 1'b0;
					if (!cmd_empty) begin
						cmd_q              <= cmd;
						res_q.best_task    <= peek_hit ? best_task_q : cmd.task_id;
						res_q.result_value <= peek_hit ? best_val_q : '0;
						res_q.status       <= ((cmd.op == hvtq_pkg::OP_PEEK) && !peek_hit) ?
						                      hvtq_pkg::ST_EMPTY : hvtq_pkg::ST_OK;
						res_q.queued_count <= 6'(count_q);
						case (cmd.op)
							hvtq_pkg::OP_ENQ: state_q <= S_DSQ;
							hvtq_pkg::OP_REM: state_q <= S_SCAN;
							default:          state_q <= S_OUT;
						endcase
					end
				end
				S_DSQ: begin
					dsq_q   <= 64'(cmd_q.diff) * 64'(cmd_q.diff);
					cur_q   <= cmd_q.task_value;
					state_q <= S_M1;
				end
				S_M1: begin
					prod_q  <= 71'(cur_q) * 71'(cmd_q.cpu_ms);
					state_q <= S_R1;
				end
				S_R1: begin
					if (cmd_q.slice_over) begin
						cur_q <= cut_value(cur_q, prod_q);
					end
					state_q <= S_M2;
				end
				S_M2: begin
					prod_q  <= 71'(cur_q) * 71'(dsq_q);
					state_q <= S_R2;
				end
				S_R2: begin
					if (cmd_q.overrun) begin
						cur_q <= cut_value(cur_q, prod_q);
					end
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (cnt_q < (IW+1)'(MAX_TASKS)) begin
						rd_vld_s1 <= 1'b1;
						cnt_q     <= cnt_q + 1'b1;
					end else begin
						rd_vld_s1 <= 1'b0;
						state_q   <= S_FIN;
					end
					if (rd_vld_s1) begin
						if (rd_valid_s1 && (rd_task_s1 == cmd_q.task_id)) begin
							found_q     <= 1'b1;
							found_idx_q <= rd_idx_s1;
						end
						if (!rd_valid_s1 && !free_seen_q) begin
							free_seen_q <= 1'b1;
							free_idx_q  <= rd_idx_s1;
						end
						if (rd_valid_s1 && (rd_task_s1 != cmd_q.task_id) &&
						    (!bfound_q || (rd_val_s1 > bval_q) ||
						     ((rd_val_s1 == bval_q) && (age_dist > bdist_q)))) begin
							bfound_q <= 1'b1;
							bidx_q   <= rd_idx_s1;
							bval_q   <= rd_val_s1;
							btask_q  <= rd_task_s1;
							bdist_q  <= age_dist;
						end
					end
				end
				S_FIN: begin
					state_q <= S_OUT;
					if (cmd_q.op == hvtq_pkg::OP_ENQ) begin
						if (found_q) begin
							res_q.status <= hvtq_pkg::ST_DUP;
						end else if (!enq_ok) begin
							res_q.status <= hvtq_pkg::ST_FULL;
						end else begin
							valid_q[free_idx_q] <= 1'b1;
							arrival_q           <= arrival_q + 1'b1;
							if ((count_q == '0) || (cur_q > best_val_q)) begin
								best_idx_q  <= free_idx_q;
								best_val_q  <= cur_q;
								best_task_q <= cmd_q.task_id;
							end
							count_q            <= count_q + 1'b1;
							res_q.result_value <= cur_q;
							res_q.queued_count <= 6'(count_q + 1'b1);
						end
					end else begin
						if (!found_q) begin
							res_q.status <= hvtq_pkg::ST_NOTFOUND;
						end else begin
							valid_q[found_idx_q] <= 1'b0;
							count_q              <= count_q - 1'b1;
							res_q.queued_count   <= 6'(count_q - 1'b1);
							if (found_idx_q == best_idx_q) begin
								best_idx_q  <= bfound_q ? bidx_q : '0;
								best_val_q  <= bval_q;
								best_task_q <= btask_q;
							end
						end
					end
				end
				S_OUT: begin
					if (!res_full) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/highest_value_task_queue.sv =====
// A new transaction is taken only once the last one has left the back part.
// Remove and enqueue run the slot scan over the slot memory (one slot read per cycle);
// an enqueue first runs the two multiply-and-cut steps.
// Reset clears slot valid flags, counters, best-task registers and both queues;
// slot memories need no clearing pass.
// Top level of the task queue; depends on hvtq_pkg, hvtq_front, hvtq_back, hvtq_fifo.
`default_nettype none

module highest_value_task_queue #(
	parameter int MAX_TASKS = hvtq_pkg::MAX_TASKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  hvtq_pkg::in_item_t  item,
	output logic                full,
	input  logic                pop,
	output hvtq_pkg::out_item_t result,
	output logic                empty
);

	hvtq_pkg::cmd_t      cmd;
	logic                cmd_empty;
	logic                cmd_pop;
	logic                res_full;
	logic                res_push;
	hvtq_pkg::out_item_t res;
	logic [$bits(hvtq_pkg::out_item_t)-1:0] res_raw;

	hvtq_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.item  (item),
		.full  (full),
		.pop   (cmd_pop),
		.cmd   (cmd),
		.empty (cmd_empty)
	);

	hvtq_back #(
		.MAX_TASKS(MAX_TASKS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	hvtq_fifo #(
		.WIDTH($bits(hvtq_pkg::out_item_t)),
		.DEPTH(hvtq_pkg::RESQ_DEPTH)
	) u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_raw),
		.empty (empty)
	);

	assign result = hvtq_pkg::out_item_t'(res_raw);

endmodule

`default_nettype wire

// ===== rtl/core/hvtq_checker.sv =====
// Port-level checks for the task queue and their bind to the top level.
// Depends on hvtq_pkg and highest_value_task_queue.
`default_nettype none

module hvtq_checker #(
	parameter int MAX_TASKS = hvtq_pkg::MAX_TASKS_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                pop,
	input logic                empty,
	input hvtq_pkg::out_item_t result
);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.status <= hvtq_pkg::ST_DUP))
		else $error("status code out of range");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.status == hvtq_pkg::ST_EMPTY)) |-> (result.queued_count == '0))
		else $error("empty status with tasks queued");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.status == hvtq_pkg::ST_FULL)) |->
		(result.queued_count == 6'(MAX_TASKS)))
		else $error("full status below capacity");

	a_ok_value: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.status != hvtq_pkg::ST_OK)) |-> (result.result_value == '0))
		else $error("value reported on failed transaction");

endmodule

bind highest_value_task_queue hvtq_checker #(.MAX_TASKS(MAX_TASKS)) u_hvtq_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.pop   (pop),
	.empty (empty),
	.result(result)
);

`default_nettype wire

// ===== sim/highest_value_task_queue_test.sv =====
// Testbench for highest_value_task_queue: directed and random transactions against a model.
// Depends on hvtq_pkg and the highest_value_task_queue RTL.
`default_nettype none

class hvtq_scoreboard;
	localparam int SLOTS = 32;
	bit          valid_q[SLOTS];
	logic [7:0]  id_q[SLOTS];
	logic [6:0]  value_q[SLOTS];
	logic [15:0] age_q[SLOTS];
	logic [15:0] arrivals;
	int          best;
	int          count;
	hvtq_pkg::out_item_t pending[$];
	int          errors;

	function new();
		for (int s = 0; s < SLOTS; s++) valid_q[s] = 0;
		arrivals = 0;
		best = 0;
		count = 0;
		errors = 0;
	endfunction

	function longint unsigned cut(longint unsigned old, longint unsigned mult);
		longint unsigned c;
		if (old == 0) return 64'(hvtq_pkg::ZERO_FLOOR);
		if (mult > 64'hFFFF_FFFF_FFFF_FFFF / old) return 0;
		c = mult * old / 64'(hvtq_pkg::PCT_BASE);
		if (c >= old) return 0;
		return old - c;
	endfunction

	function logic [15:0] seniority(int s);
		return arrivals - age_q[s];
	endfunction

	function void rescan();
		bit hit;
		hit = 0;
		best = 0;
		for (int s = 0; s < SLOTS; s++) begin
			if (!valid_q[s]) continue;
			if (!hit || value_q[s] > value_q[best] ||
					(value_q[s] == value_q[best] && seniority(s) > seniority(best))) begin
				best = s;
				hit = 1;
			end
		end
	endfunction

	function int lookup(logic [7:0] id);
		for (int s = 0; s < SLOTS; s++)
			if (valid_q[s] && id_q[s] == id) return s;
		return -1;
	endfunction

	function void note_item(hvtq_pkg::in_item_t it);
		hvtq_pkg::out_item_t r;
		longint unsigned v, d;
		int s;
		r.best_task = it.task_id;
		r.result_value = 0;
		r.status = hvtq_pkg::ST_OK;
		case (it.action)
			hvtq_pkg::OP_ENQ: begin
				if (lookup(it.task_id) >= 0) r.status = hvtq_pkg::ST_DUP;
				else if (count >= SLOTS) r.status = hvtq_pkg::ST_FULL;
				else begin
					v = 64'(it.task_value);
					if (it.slice_over) v = cut(v, 64'(it.cpu_ms));
					if (it.cpu_ms > it.budget_ms) begin
						d = 64'(it.cpu_ms) - 64'(it.budget_ms);
						v = cut(v, d * d);
					end
					v &= 7'h7F;
					s = 0;
					while (valid_q[s]) s++;
					valid_q[s] = 1;
					id_q[s] = it.task_id;
					value_q[s] = v[6:0];
					age_q[s] = arrivals;
					arrivals++;
					if (count == 0 || v[6:0] > value_q[best]) best = s;
					count++;
					r.result_value = v[6:0];
				end
			end
			hvtq_pkg::OP_REM: begin
				s = lookup(it.task_id);
				if (s < 0) r.status = hvtq_pkg::ST_NOTFOUND;
				else begin
					valid_q[s] = 0;
					count--;
					if (s == best) rescan();
				end
			end
			hvtq_pkg::OP_PEEK: begin
				if (count == 0 || !valid_q[best]) r.status = hvtq_pkg::ST_EMPTY;
				else begin
					r.best_task = id_q[best];
					r.result_value = value_q[best];
				end
			end
			default: ;
		endcase
		r.queued_count = count[5:0];
		pending.push_back(r);
	endfunction

	function void check_result(hvtq_pkg::out_item_t got);
		hvtq_pkg::out_item_t exp;
		if (pending.size() == 0) begin
			$error("unexpected transaction %h", got);
			errors++;
			return;
		end
		exp = pending.pop_front();
		if (got.best_task !== exp.best_task) begin
			$error("best_task expected %0d actual %0d", exp.best_task, got.best_task);
			errors++;
		end
		if (got.result_value !== exp.result_value) begin
			$error("result_value expected %0d actual %0d", exp.result_value, got.result_value);
			errors++;
		end
		if (got.status !== exp.status) begin
			$error("status expected %0d actual %0d", exp.status, got.status);
			errors++;
		end
		if (got.queued_count !== exp.queued_count) begin
			$error("queued_count expected %0d actual %0d", exp.queued_count, got.queued_count);
			errors++;
		end
	endfunction
endclass

module highest_value_task_queue_test;

	logic                clk = 0;
	logic                arst_n = 0;
	logic                push = 0;
	hvtq_pkg::in_item_t  item = '0;
	logic                full;
	logic                pop = 0;
	hvtq_pkg::out_item_t result;
	logic                empty;
	bit                  sending_done = 0;
	hvtq_scoreboard      board = new();

	highest_value_task_queue dut (
		.clk(clk), .arst_n(arst_n), .push(push), .item(item), .full(full),
		.pop(pop), .result(result), .empty(empty)
	);

	always #5 clk = ~clk;

	task automatic send(hvtq_pkg::in_item_t it);
		int gap;
		gap = $urandom_range(0, 10);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			push <= 0;
			repeat (gap) @(posedge clk);
		end
		push <= 1;
		item <= it;
		do @(posedge clk); while (full);
		board.note_item(it);
	endtask

	task automatic drain();
		push <= 0;
		do @(posedge clk); while (board.pending.size() != 0);
	endtask

	function automatic hvtq_pkg::in_item_t make(hvtq_pkg::op_t op, logic [7:0] id,
			logic [6:0] v, logic [31:0] used, logic [31:0] ct, logic ex);
		hvtq_pkg::in_item_t it;
		it.action = op;
		it.task_id = id;
		it.task_value = v;
		it.cpu_ms = used;
		it.budget_ms = ct;
		it.slice_over = ex;
		return it;
	endfunction

	function automatic logic [31:0] pick_time();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(0, 12);
		endcase
	endfunction

	task automatic send_random();
		hvtq_pkg::op_t op;
		int r;
		r = $urandom_range(0, 19);
		op = r < 9 ? hvtq_pkg::OP_ENQ : r < 15 ? hvtq_pkg::OP_REM :
			r < 19 ? hvtq_pkg::OP_PEEK : hvtq_pkg::OP_NOP;
		send(make(op, $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 40)),
			$urandom_range(0, 4) == 0 ? 7'($urandom) : 7'($urandom_range(0, 100)),
			pick_time(), pick_time(), 1'($urandom)));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send(make(hvtq_pkg::OP_PEEK, 8'd7, 0, 0, 0, 0));
		send(make(hvtq_pkg::OP_REM, 8'd7, 0, 0, 0, 0));
		send(make(hvtq_pkg::OP_NOP, 8'hFF, 7'h7F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
		send(make(hvtq_pkg::OP_ENQ, 8'd0, 7'd100, 0, 0, 0));
		send(make(hvtq_pkg::OP_ENQ, 8'd0, 7'd50, 0, 0, 0));
		send(make(hvtq_pkg::OP_ENQ, 8'hFF, 7'd100, 0, 5, 1));
		send(make(hvtq_pkg::OP_ENQ, 8'd1, 7'd0, 5, 0, 1));
		send(make(hvtq_pkg::OP_ENQ, 8'd2, 7'd80, 32'd20, 32'd100, 1));
		send(make(hvtq_pkg::OP_ENQ, 8'd3, 7'd80, 32'd150, 32'd0, 1));
		send(make(hvtq_pkg::OP_ENQ, 8'd4, 7'h7F, 32'hFFFF_FFFF, 32'd0, 0));
		send(make(hvtq_pkg::OP_ENQ, 8'd5, 7'h7F, 32'd3, 32'd1, 0));
		send(make(hvtq_pkg::OP_ENQ, 8'd6, 7'h7F, 0, 0, 1));
		send(make(hvtq_pkg::OP_PEEK, 0, 0, 0, 0, 0));
		send(make(hvtq_pkg::OP_REM, 8'd0, 0, 0, 0, 0));
		send(make(hvtq_pkg::OP_PEEK, 0, 0, 0, 0, 0));
		for (int i = 10; i < 40; i++) send(make(hvtq_pkg::OP_ENQ, i[7:0], 7'd60, 0, 0, 0));
		send(make(hvtq_pkg::OP_PEEK, 0, 0, 0, 0, 0));
		drain();
		for (int i = 0; i < 500; i++) begin
			if (i == 250)
				drain();
			send_random();
		end
		push <= 0;
		sending_done = 1;
	end

	initial begin
		forever begin
			int stall;
			@(posedge clk);
			stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 10);
			if (stall != 0) begin
				pop <= 0;
				repeat (stall - 1) @(posedge clk);
			end else begin
				pop <= 1;
				do @(posedge clk); while (empty);
				board.check_result(result);
				pop <= 0;
			end
		end
	end

	initial begin
		wait (sending_done);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end
endmodule

`default_nettype wire

// ===== highest_value_task_queue.f =====
rtl/core/hvtq_pkg.sv
rtl/core/hvtq_fifo.sv
rtl/core/hvtq_front.sv
rtl/core/hvtq_back.sv
rtl/core/highest_value_task_queue.sv
rtl/core/hvtq_checker.sv
sim/highest_value_task_queue_test.sv
